[rtl/whc_pkg.sv]
// Package for the word hash combiner: mixer constants and the operation record
// that travels from the front end through the queue to the back end.
// No dependencies.
package whc_pkg;

  localparam logic [31:0] SEED_INIT = 32'h56af121f;
  localparam logic [31:0] MIX_MUL   = 32'h045d9f3b;
  localparam logic [31:0] GOLDEN    = 32'h9e3779b9;

  typedef enum logic [1:0] {
    OP_SHORT = 2'd0,
    OP_FIRST = 2'd1,
    OP_FOLD  = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic        last;
    logic [29:0] words;
    logic [31:0] word;
  } op_t;

endpackage

[rtl/whc_front.sv]
// Front end of the word hash combiner: takes message items, tracks the word count
// and tail flag, and turns each item of a message into an operation for the back end.
// Depends on whc_pkg.
module whc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [31:0]    data_word,
  input  logic [31:0]    message_bytes,
  input  logic           start_req,
  output logic           push,
  output whc_pkg::op_t   push_op
);

  logic [29:0] words_left;
  logic [29:0] words_left_next;
  logic        tail_pending;
  logic        tail_pending_next;
  logic        in_message;
  logic        in_message_next;
  logic [31:0] short_mask;
  logic [29:0] word_count;
  logic [29:0] first_left;
  logic        first_tail;

  assign word_count = message_bytes[31:2];
  assign first_left = word_count - 30'd1;
  assign first_tail = message_bytes[1:0] != 2'd0;

  always_comb begin
    unique case (message_bytes[1:0])
      2'd0:    short_mask = 32'h00000000;
      2'd1:    short_mask = 32'h000000ff;
      2'd2:    short_mask = 32'h0000ffff;
      default: short_mask = 32'h00ffffff;
    endcase
  end

  always_comb begin
    words_left_next   = words_left;
    tail_pending_next = tail_pending;
    in_message_next   = in_message;
    push              = 1'b0;
    push_op.kind      = whc_pkg::OP_FOLD;
    push_op.last      = 1'b0;
    push_op.words     = word_count;
    push_op.word      = data_word;
    priority if (start_req && (word_count == 30'd0)) begin
      push              = take;
      push_op.kind      = whc_pkg::OP_SHORT;
      push_op.last      = 1'b1;
      push_op.word      = (whc_pkg::SEED_INIT & ~short_mask) | (data_word & short_mask);
      words_left_next   = 30'd0;
      tail_pending_next = 1'b0;
      in_message_next   = 1'b0;
    end else if (start_req) begin
      push              = take;
      push_op.kind      = whc_pkg::OP_FIRST;
      push_op.last      = (first_left == 30'd0) && !first_tail;
      words_left_next   = first_left;
      tail_pending_next = first_tail;
      in_message_next   = !push_op.last;
    end else if (in_message) begin
      push = take;
      if (words_left != 30'd0) begin
        words_left_next = words_left - 30'd1;
        push_op.last    = (words_left_next == 30'd0) && !tail_pending;
      end else begin
        tail_pending_next = 1'b0;
        push_op.last      = 1'b1;
      end
      in_message_next = !push_op.last;
    end else begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_left   <= 30'd0;
      tail_pending <= 1'b0;
      in_message   <= 1'b0;
    end else if (take) begin
      words_left   <= words_left_next;
      tail_pending <= tail_pending_next;
      in_message   <= in_message_next;
    end
  end

`ifndef ASSERT_OFF
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !in_message |-> (words_left == 30'd0) && !tail_pending)
    else $error("front idle with words or tail still pending");
`endif

endmodule

[rtl/whc_queue.sv]
// Short operation queue between the front end and the back end of the word
// hash combiner. Depends on whc_pkg.
module whc_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  whc_pkg::op_t   push_op,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output whc_pkg::op_t   pop_op
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  whc_pkg::op_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != CW'(0);
  assign pop_op    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");
`endif

endmodule

[rtl/whc_back.sv]
// Back end of the word hash combiner: a three-stage integer mixer followed by
// the seed combine and the result register. Depends on whc_pkg.
module whc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           op_ready,
  input  whc_pkg::op_t   op,
  output logic           pop,
  output logic           hash_valid,
  input  logic           hash_stall,
  output logic [31:0]    hash_value
);

  logic        advance;
  logic        a_valid;
  logic        b_valid;
  logic        c_valid;
  whc_pkg::op_kind_t a_kind;
  whc_pkg::op_kind_t b_kind;
  whc_pkg::op_kind_t c_kind;
  logic        a_last;
  logic        b_last;
  logic        c_last;
  logic [29:0] a_words;
  logic [29:0] b_words;
  logic [29:0] c_words;
  logic [31:0] a_x;
  logic [31:0] b_x;
  logic [31:0] c_t;
  logic [31:0] a_x_next;
  logic [31:0] b_x_next;
  logic [31:0] c_v;
  logic [31:0] c_t_next;
  logic [31:0] seed;
  logic [31:0] seed_next;
  logic [31:0] hash_next;

  assign advance = !(hash_valid && hash_stall);
  assign pop     = advance && op_ready;

  assign a_x_next = (op.word ^ (op.word >> 16)) * whc_pkg::MIX_MUL;
  assign b_x_next = (a_x ^ (a_x >> 16)) * whc_pkg::MIX_MUL;
  assign c_v      = b_x ^ (b_x >> 16);

  always_comb begin
    if (b_kind == whc_pkg::OP_SHORT) begin
      c_t_next = c_v;
    end else begin
      c_t_next = c_v + whc_pkg::GOLDEN + (c_v << 6) + (c_v >> 2);
    end
  end

  always_comb begin
    seed_next = seed;
    hash_next = seed;
    unique case (c_kind)
      whc_pkg::OP_SHORT: begin
        hash_next = c_t;
      end
      whc_pkg::OP_FIRST: begin
        seed_next = whc_pkg::SEED_INIT ^ {2'b00, c_words} ^ c_t;
        hash_next = seed_next;
      end
      whc_pkg::OP_FOLD: begin
        seed_next = seed ^ c_t;
        hash_next = seed_next;
      end
      default: begin
        seed_next = seed;
        hash_next = seed;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      c_valid    <= 1'b0;
      hash_valid <= 1'b0;
      seed       <= '0;
    end else if (advance) begin
      a_valid    <= op_ready;
      b_valid    <= a_valid;
      c_valid    <= b_valid;
      hash_valid <= c_valid && c_last;
      if (c_valid) begin
        seed <= seed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_kind  <= op.kind;
      a_last  <= op.last;
      a_words <= op.words;
      a_x     <= a_x_next;
      b_kind  <= a_kind;
      b_last  <= a_last;
      b_words <= a_words;
      b_x     <= b_x_next;
      c_kind  <= b_kind;
      c_last  <= b_last;
      c_words <= b_words;
      c_t     <= c_t_next;
      if (c_valid) begin
        hash_value <= hash_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_seed_frozen: assert property (@(posedge clk) disable iff (rst)
    hash_valid && hash_stall |=> $stable(seed))
    else $error("seed changed while the result was held");
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    advance && !(c_valid && c_last) |=> !hash_valid)
    else $error("result raised without a final operation");
`endif

endmodule

[rtl/word_hash_combine.sv]
// Top level of the word hash combiner: front end, operation queue and back end.
// Depends on whc_pkg, whc_front, whc_queue and whc_back.
//
// A message enters on the item channel (item_valid / item_stall) as 32-bit
// little-endian words. The item with start_req set carries message_bytes and
// the first word; whole words follow, then one overlapping tail word when the
// length is not a multiple of four. Messages of zero to three bytes are a
// single item. The 32-bit hash leaves on the result channel (hash_valid /
// hash_stall) after the item that completes the message.
// One item is taken per cycle while item_stall is low. After its last item, a result
// passes the queue, the three mixer stages and the result register; the seed
// combine is only XOR logic on the final stage, so it does not limit the rate.
// While the receiver stalls, the result register holds and the back end
// freezes; the queue of QUEUE_DEPTH entries then fills and item_stall rises.
// Reset empties the queue and pipeline and abandons any message in progress.
module word_hash_combine #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [31:0] data_word,
  input  logic [31:0] message_bytes,
  input  logic        start_req,
  output logic        hash_valid,
  input  logic        hash_stall,
  output logic [31:0] hash_value
);

  logic         take;
  logic         push;
  logic         pop;
  logic         full;
  logic         op_ready;
  whc_pkg::op_t push_op;
  whc_pkg::op_t pop_op;

  assign item_stall = full;
  assign take       = item_valid && !full;

  whc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_word     (data_word),
    .message_bytes (message_bytes),
    .start_req     (start_req),
    .push          (push),
    .push_op       (push_op)
  );

  whc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .pop       (pop),
    .full      (full),
    .not_empty (op_ready),
    .pop_op    (pop_op)
  );

  whc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .op_ready   (op_ready),
    .op         (pop_op),
    .pop        (pop),
    .hash_valid (hash_valid),
    .hash_stall (hash_stall),
    .hash_value (hash_value)
  );

endmodule

[bench/word_hash_checker.sv]
// Checker for the word hash combiner: watches the item and hash channels, keeps
// its own copy of the hashing state, predicts every hash and compares it.
// Depends only on the ports of word_hash_combine.
`timescale 1ns / 100ps

module word_hash_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic [31:0] data_word,
  input  logic [31:0] message_bytes,
  input  logic        start_req,
  input  logic        hash_valid,
  input  logic        hash_stall,
  input  logic [31:0] hash_value,
  output int          error_count,
  output int          hashes_owed
);

  localparam logic [31:0] SEED_BASE   = 32'h56af121f;
  localparam logic [31:0] MIX_FACTOR  = 32'h045d9f3b;
  localparam logic [31:0] GOLDEN_STEP = 32'h9e3779b9;

  logic [31:0] seed_acc;
  logic [29:0] words_remaining;
  logic        tail_owed;
  logic        msg_open;
  logic [31:0] oldest_hash;
  logic [31:0] hashes_due[$];

  function automatic logic [31:0] mix_word(input logic [31:0] x);
    x = ((x >> 16) ^ x) * MIX_FACTOR;
    x = ((x >> 16) ^ x) * MIX_FACTOR;
    return (x >> 16) ^ x;
  endfunction

  function automatic logic [31:0] absorb_word(input logic [31:0] seed, input logic [31:0] word);
    logic [31:0] v;
    v = mix_word(word);
    return seed ^ (v + GOLDEN_STEP + (v << 6) + (v >> 2));
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic predict_hash(input logic [31:0] word, input logic [31:0] len,
                              input logic start);
    logic [31:0] mask;
    logic [31:0] whole;
    if (start) begin
      if (len < 32'd4) begin
        mask = (len == 32'd0) ? 32'd0 : (32'd1 << (len * 8)) - 32'd1;
        seed_acc = '0;
        words_remaining = '0;
        tail_owed = 1'b0;
        msg_open = 1'b0;
        hashes_due.push_back(mix_word((SEED_BASE & ~mask) | (word & mask)));
        return;
      end
      whole = len >> 2;
      seed_acc = absorb_word(SEED_BASE ^ whole, word);
      words_remaining = whole[29:0] - 30'd1;
      tail_owed = (len[1:0] != 2'd0);
      msg_open = 1'b1;
    end else begin
      if (!msg_open) return;
      seed_acc = absorb_word(seed_acc, word);
      if (words_remaining != 30'd0) words_remaining = words_remaining - 30'd1;
      else tail_owed = 1'b0;
    end
    if (words_remaining == 30'd0 && !tail_owed) begin
      msg_open = 1'b0;
      hashes_due.push_back(seed_acc);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seed_acc = '0;
      words_remaining = '0;
      tail_owed = 1'b0;
      msg_open = 1'b0;
      hashes_due.delete();
      hashes_owed = 0;
    end else begin
      if (hash_valid && !hash_stall) begin
        if (hashes_due.size() == 0) begin
          flag_mismatch($sformatf("hash %h arrived with none outstanding", hash_value));
        end else begin
          oldest_hash = hashes_due.pop_front();
          if (hash_value !== oldest_hash) begin
            flag_mismatch($sformatf("hash_value %h, predicted %h", hash_value, oldest_hash));
          end
        end
      end
      if (item_valid && !item_stall) predict_hash(data_word, message_bytes, start_req);
      hashes_owed = hashes_due.size();
    end
  end

endmodule

[bench/word_hash_combine_tb.sv]
// Top of the word hash combiner bench: clock, reset, item stimulus and the
// receiver, with word_hash_checker beside the block doing all comparisons.
// Depends on word_hash_combine and word_hash_checker.
`timescale 1ns / 100ps

module word_hash_combine_tb;

  localparam int RANDOM_ITEMS = 650;
  localparam int PHASES       = 5;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic [31:0] data_word = '0;
  logic [31:0] message_bytes = '0;
  logic        start_req = 1'b0;
  logic        hash_stall = 1'b0;
  logic        item_stall;
  logic        hash_valid;
  logic [31:0] hash_value;

  int error_count;
  int hashes_owed;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int items_fed = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  word_hash_combine DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .data_word    (data_word),
    .message_bytes(message_bytes),
    .start_req    (start_req),
    .hash_valid   (hash_valid),
    .hash_stall   (hash_stall),
    .hash_value   (hash_value)
  );

  word_hash_checker u_hash_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .data_word    (data_word),
    .message_bytes(message_bytes),
    .start_req    (start_req),
    .hash_valid   (hash_valid),
    .hash_stall   (hash_stall),
    .hash_value   (hash_value),
    .error_count  (error_count),
    .hashes_owed  (hashes_owed)
  );

  // A long hold is counted here so that the sender keeps offering items meanwhile.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        hash_stall <= 1'b1;
      end else begin
        hash_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  task automatic push_item(input logic [31:0] word, input logic [31:0] len,
                           input logic start, input bit counted);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    data_word <= word;
    message_bytes <= len;
    start_req <= start;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (counted) items_fed++;
  endtask

  task automatic deliver_message(input logic [31:0] len, input longint keep);
    longint total;
    total = (len < 32'd4) ? 1 : longint'(len >> 2) + (len[1:0] != 2'd0);
    for (longint k = 0; k < total && k < keep; k++) begin
      push_item($urandom, (k == 0) ? len : $urandom, k == 0, 1'b1);
    end
  endtask

  task automatic random_message();
    logic [31:0] len;
    longint      total;
    longint      keep;
    int          pick;
    if ($urandom_range(99) < 8) push_item($urandom, $urandom, 1'b0, 1'b0);
    pick = $urandom_range(99);
    if (pick < 45) len = $urandom_range(15);
    else if (pick < 80) len = $urandom_range(64, 16);
    else if (pick < 95) len = $urandom_range(160, 65);
    else len = $urandom;
    total = (len < 32'd4) ? 1 : longint'(len >> 2) + (len[1:0] != 2'd0);
    if (pick >= 95) keep = $urandom_range(4, 1);
    else if ($urandom_range(99) < 12) keep = $urandom_range(int'(total), 1);
    else keep = total;
    deliver_message(len, keep);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_item(32'hffffffff, 32'd0, 1'b1, 1'b1);
    push_item(32'hffffffff, 32'd1, 1'b1, 1'b1);
    push_item(32'h00000000, 32'd2, 1'b1, 1'b1);
    push_item(32'hffffffff, 32'd3, 1'b1, 1'b1);
    push_item(32'h12345678, 32'd3, 1'b1, 1'b1);
    push_item(32'hffffffff, 32'd4, 1'b1, 1'b1);
    push_item(32'h00000000, 32'd8, 1'b1, 1'b1);
    push_item(32'hffffffff, 32'hffffffff, 1'b0, 1'b1);
    push_item(32'hffffffff, 32'd7, 1'b1, 1'b1);
    push_item(32'h00000000, 32'h00000000, 1'b0, 1'b1);
    push_item(32'hffffffff, 32'hffffffff, 1'b0, 1'b0);
    push_item(32'hffffffff, 32'hffffffff, 1'b1, 1'b1);
    push_item(32'h00000000, 32'h00000000, 1'b0, 1'b1);
    push_item(32'hffffffff, 32'h00000000, 1'b0, 1'b1);
    push_item(32'ha5a5a5a5, 32'd6, 1'b1, 1'b1);
    push_item(32'h5a5a5a5a, 32'hffffffff, 1'b0, 1'b1);
    push_item(32'h00000000, 32'hfffffffc, 1'b1, 1'b1);
    push_item(32'hffffffff, 32'h00000000, 1'b0, 1'b1);
    push_item(32'hc3c3c3c3, 32'd2, 1'b1, 1'b1);

    items_fed = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 57;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 57;
        end
        3: begin
          sender_idle_pct = 10;
          receiver_stall_pct = 10;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
          holds_asked++;
        end
      endcase
      while (items_fed < (ph + 1) * RANDOM_ITEMS / PHASES) random_message();
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (hashes_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && hashes_owed == 0) begin
      $display("word_hash_combine test passed");
    end else begin
      $display("word_hash_combine test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("word_hash_combine test failed");
    $finish;
  end

endmodule

[sim.f]
rtl/whc_pkg.sv
rtl/whc_front.sv
rtl/whc_queue.sv
rtl/whc_back.sv
rtl/word_hash_combine.sv
bench/word_hash_checker.sv
bench/word_hash_combine_tb.sv
